/* design/lcaq_pkg.sv */
// Shared constants, types and helpers for the line command assembler queue.
package lcaq_pkg;

    // Line buffer size; a line holds at most LINE_MAX-1 characters.
    localparam int LINE_MAX    = 32;
    // Number of finished lines the queue keeps.
    localparam int QUEUE_SLOTS = 4;
    // One extra physical slot holds the line being assembled.
    localparam int PHYS_SLOTS  = QUEUE_SLOTS + 1;
    localparam int MEM_DEPTH   = PHYS_SLOTS * LINE_MAX;

    localparam int LEN_W  = $clog2(LINE_MAX);
    localparam int SLOT_W = (PHYS_SLOTS > 1) ? $clog2(PHYS_SLOTS) : 1;
    localparam int HELD_W = $clog2(QUEUE_SLOTS + 1);
    localparam int ADDR_W = $clog2(MEM_DEPTH);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        CMD_BYTE      = 2'd0,
        CMD_BURST_END = 2'd1,
        CMD_ERROR     = 2'd2,
        CMD_GET       = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_STREAM = 1'b1
    } t_state;

    typedef struct packed {
        logic       found;
        logic [7:0] line_char;
        logic       last;
    } t_result;

    // Advance a ring pointer over the physical slots.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(PHYS_SLOTS - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    // Character address inside the line RAM.
    function automatic logic [ADDR_W-1:0] char_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [LEN_W-1:0] idx);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(ADDR_W'(s) * ADDR_W'(LINE_MAX)) + ADDR_W'(idx);
        return a;
    endfunction

endpackage

/* design/line_command_assembler_queue.sv */
// Top level: assembles received bytes into lines and queues them for readout.
//
//  Channel | Direction | Handshake            | Fields
//  --------+-----------+----------------------+---------------------------------
//  input   | in        | i_valid / o_stall    | i_command, i_rx_byte
//  output  | out       | o_valid / i_stall    | o_found, o_line_char, o_last
//
// Byte, end-of-burst and error words are taken one per cycle while not stalled.
// A get word takes the oldest line; it is then read from the line RAM one
// character per cycle while the output queue has room, and input is held off
// until its last character is read. A get on an empty queue gives one word.
// Reset is synchronous and clears the pointers, counts and output queue; no
// memory clearing pass is needed. A stalled output fills a two-word output
// queue, after which RAM reads pause until the consumer takes a word.
module line_command_assembler_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_found,
    output logic [7:0] o_line_char,
    output logic       o_last
);

    localparam int SW = lcaq_pkg::SLOT_W;
    localparam int LW = lcaq_pkg::LEN_W;
    localparam int HW = lcaq_pkg::HELD_W;
    localparam int AW = lcaq_pkg::ADDR_W;

    // Control state.
    lcaq_pkg::t_state r_state, n_state;
    logic [LW-1:0]    r_part_len, n_part_len;
    logic [SW-1:0]    r_wr_slot, n_wr_slot;
    logic [SW-1:0]    r_rd_slot, n_rd_slot;
    logic [HW-1:0]    r_held, n_held;
    logic [SW-1:0]    r_str_slot, n_str_slot;
    logic [LW-1:0]    r_str_len, n_str_len;
    logic [LW-1:0]    r_str_idx, n_str_idx;
    logic             r_infl, n_infl;
    logic             r_infl_last, n_infl_last;

    // Stored line lengths, one per physical slot.
    logic [LW-1:0]    r_len_tab [lcaq_pkg::PHYS_SLOTS];

    // Two-word output queue.
    lcaq_pkg::t_result r_oq [2];
    logic              r_oq_wp, r_oq_rp;
    logic [1:0]        r_oq_cnt;

    // Handshake and datapath controls.
    logic              in_acc;
    logic              pop;
    logic              push;
    lcaq_pkg::t_result push_word;
    logic              issue;
    logic              issue_last;
    logic [1:0]        occ;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;
    logic              len_we;
    lcaq_pkg::t_cmd    cmd;
    logic              is_term;
    logic              do_close;
    logic              get_empty;
    logic              get_line;

    lcaq_line_ram #(
        .DEPTH (lcaq_pkg::MEM_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (issue),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake outputs.
    always_comb begin
        o_stall     = (r_state != lcaq_pkg::ST_IDLE) || r_infl || (r_oq_cnt == 2'd2);
        o_valid     = (r_oq_cnt != 2'd0);
        o_found     = r_oq[r_oq_rp].found;
        o_line_char = r_oq[r_oq_rp].line_char;
        o_last      = r_oq[r_oq_rp].last;
    end

    assign in_acc = i_valid && !o_stall;
    assign pop    = o_valid && !i_stall;
    assign cmd    = lcaq_pkg::t_cmd'(i_command);

    // Decode of the accepted word.
    always_comb begin
        is_term   = (i_rx_byte == lcaq_pkg::CH_CR) || (i_rx_byte == lcaq_pkg::CH_LF);
        do_close  = 1'b0;
        get_empty = 1'b0;
        get_line  = 1'b0;
        if (in_acc) begin
            unique case (cmd)
                lcaq_pkg::CMD_BYTE:      do_close = is_term && (r_part_len != '0);
                lcaq_pkg::CMD_BURST_END: do_close = (r_part_len != '0);
                lcaq_pkg::CMD_ERROR:     do_close = 1'b0;
                lcaq_pkg::CMD_GET: begin
                    get_empty = (r_held == '0);
                    get_line  = (r_held != '0);
                end
            endcase
        end
    end

    // RAM read issue: keep queued plus in-flight words within the output queue.
    always_comb begin
        occ        = r_oq_cnt + {1'b0, r_infl};
        issue      = (r_state == lcaq_pkg::ST_STREAM) &&
                     ((occ < 2'd2) || (pop && (occ == 2'd2)));
        issue_last = (r_str_idx == (r_str_len - LW'(1)));
        ram_raddr  = lcaq_pkg::char_addr(r_str_slot, r_str_idx);
    end

    // Line assembly, queue pointers and stream control.
    always_comb begin
        n_part_len  = r_part_len;
        n_wr_slot   = r_wr_slot;
        n_rd_slot   = r_rd_slot;
        n_held      = r_held;
        n_str_slot  = r_str_slot;
        n_str_len   = r_str_len;
        n_str_idx   = r_str_idx;
        n_infl      = issue;
        n_infl_last = issue && issue_last;
        ram_we      = 1'b0;
        ram_waddr   = lcaq_pkg::char_addr(r_wr_slot, r_part_len);
        len_we      = 1'b0;

        if (in_acc && (cmd == lcaq_pkg::CMD_BYTE) && !is_term) begin
            if (r_part_len < LW'(lcaq_pkg::LINE_MAX - 1)) begin
                ram_we     = 1'b1;
                n_part_len = r_part_len + 1'b1;
            end else begin
                n_part_len = '0;
            end
        end
        if (in_acc && (cmd == lcaq_pkg::CMD_ERROR)) begin
            n_part_len = '0;
        end

        // Closing a line; a full queue drops its oldest line.
        if (do_close) begin
            len_we     = 1'b1;
            n_wr_slot  = lcaq_pkg::next_slot(r_wr_slot);
            n_part_len = '0;
            if (r_held == HW'(lcaq_pkg::QUEUE_SLOTS)) begin
                n_rd_slot = lcaq_pkg::next_slot(r_rd_slot);
            end else begin
                n_held = r_held + 1'b1;
            end
        end

        // A get takes the oldest line off the queue and starts its readout.
        if (get_line) begin
            n_str_slot = r_rd_slot;
            n_str_len  = r_len_tab[r_rd_slot];
            n_str_idx  = '0;
            n_rd_slot  = lcaq_pkg::next_slot(r_rd_slot);
            n_held     = r_held - 1'b1;
        end

        if (issue) begin
            n_str_idx = r_str_idx + 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcaq_pkg::ST_IDLE: begin
                if (get_line) begin
                    n_state = lcaq_pkg::ST_STREAM;
                end
            end
            lcaq_pkg::ST_STREAM: begin
                if (issue && issue_last) begin
                    n_state = lcaq_pkg::ST_IDLE;
                end
            end
            default: n_state = lcaq_pkg::ST_IDLE;
        endcase
    end

    // Word pushed into the output queue: a RAM character or a not-found word.
    always_comb begin
        push = r_infl || get_empty;
        if (r_infl) begin
            push_word = '{found: 1'b1, line_char: ram_rdata, last: r_infl_last};
        end else begin
            push_word = '{found: 1'b0, line_char: 8'h00, last: 1'b1};
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcaq_pkg::ST_IDLE;
            r_part_len  <= '0;
            r_wr_slot   <= '0;
            r_rd_slot   <= '0;
            r_held      <= '0;
            r_str_idx   <= '0;
            r_infl      <= 1'b0;
            r_infl_last <= 1'b0;
            r_oq_wp     <= 1'b0;
            r_oq_rp     <= 1'b0;
            r_oq_cnt    <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_part_len  <= n_part_len;
            r_wr_slot   <= n_wr_slot;
            r_rd_slot   <= n_rd_slot;
            r_held      <= n_held;
            r_str_idx   <= n_str_idx;
            r_infl      <= n_infl;
            r_infl_last <= n_infl_last;
            if (push) begin
                r_oq_wp <= ~r_oq_wp;
            end
            if (pop) begin
                r_oq_rp <= ~r_oq_rp;
            end
            r_oq_cnt <= r_oq_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_str_slot <= n_str_slot;
        r_str_len  <= n_str_len;
        if (len_we) begin
            r_len_tab[r_wr_slot] <= r_part_len;
        end
        if (push) begin
            r_oq[r_oq_wp] <= push_word;
        end
    end

`ifndef ASSERT_OFF
    // The queue never counts more lines than it has slots.
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(lcaq_pkg::QUEUE_SLOTS))
        else $error("line count exceeds queue slots");

    // A word is never pushed into a full output queue unless one is popped with it.
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_oq_cnt < 2'd2))
        else $error("output queue overflow");

    // The open line's slot never coincides with the oldest queued line.
    a_slot_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != '0) |-> (r_rd_slot != r_wr_slot))
        else $error("assembly slot overlaps a queued line");

    // Leaving the readout, the character that follows carries the last mark.
    a_stream_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == lcaq_pkg::ST_STREAM) && (n_state == lcaq_pkg::ST_IDLE))
        |=> (r_infl && r_infl_last))
        else $error("readout ended without a last character");
`endif

endmodule

/* design/lcaq_line_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
module lcaq_line_ram #(
    parameter int DEPTH = 160,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, enabled by i_re.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
